/* hw/rtl/sphere_frustum_cull_macros.svh */
// Assertion macros shared by the sphere frustum cull RTL.
`ifndef SPHERE_FRUSTUM_CULL_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfc: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfc: next-cycle check failed");

`endif

/* hw/rtl/sfc_pkg.sv */
// Package: types, codes and helpers for the sphere frustum cull block.
package sfc_pkg;

   localparam int PLANE_COUNT   = 6;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAT_DEPTH     = 48;
   localparam int MAT_AW        = 6;
   localparam int PLANE_DEPTH   = PLANE_COUNT * 4;
   localparam int PLANE_AW      = 5;

   localparam logic [2:0] PLANE_LAST = 3'(PLANE_COUNT - 1);

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_LOAD_VIEW = 2'd0;
   localparam cmd_type CMD_LOAD_PROJ = 2'd1;
   localparam cmd_type CMD_DERIVE    = 2'd2;
   localparam cmd_type CMD_TEST      = 2'd3;

   // Banks of the matrix memory: view, projection, product.
   typedef logic [1:0] bank_type;
   localparam bank_type BANK_VIEW = 2'd0;
   localparam bank_type BANK_PROJ = 2'd1;
   localparam bank_type BANK_PROD = 2'd2;

   typedef struct packed {
      cmd_type            command;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic [30:0]        sphere_radius;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic is_test_result;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic       vld;
      logic       first;
      logic       last;
      logic       final_term;
      logic [1:0] sel;
      logic [3:0] idx;
   } tag_type;

   function automatic logic [31:0] sat33(input logic signed [32:0] x);
      logic [31:0] r;
      if (x[32] != x[31]) r = x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else                r = x[31:0];
      return r;
   endfunction

   function automatic logic [31:0] sat64(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (x < -64'sd2147483648) r = 32'h8000_0000;
      else                           r = x[31:0];
      return r;
   endfunction

endpackage

/* hw/rtl/sfc_mul.sv */
// Registered 32x32 signed multiplier shared by the multiply, square and test phases.
module sfc_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] prod
);
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

/* hw/rtl/sfc_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module sfc_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           radicand,
   output sfc_pkg::unit_stat_type stat,
   output logic [31:0]           root
);
   import sfc_pkg::*;

   logic [63:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic        busy_ff, busy_in, done_ff, done_in;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[31:0];
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule

/* hw/rtl/sfc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module sfc_div #(
   parameter int NUM_W = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      numer,
   input  logic [31:0]           denom,
   output sfc_pkg::unit_stat_type stat,
   output logic [NUM_W-1:0]      quot
);
   import sfc_pkg::*;

   localparam int CW = $clog2(NUM_W);

   logic [31:0]      rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [32:0]      shifted, diff;

   assign shifted = {rem_ff, q_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = denom;
         q_in    = numer;
         cnt_in  = CW'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign quot = q_ff;
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule

/* hw/rtl/sphere_frustum_cull.sv */
// Top level: frustum plane extraction from view/projection matrices and sphere culling.
//
// Usage
//   An item is taken when start is high and busy is low; its fields sit in req_payload.
//   Each item produces exactly one result on rsp_payload, marked by rsp_strobe for one
//   cycle. The receiver cannot stall, so results are never held back.
//   Load view / load projection: element written into the matrix memory, result
//     (all zero) in the next cycle; busy stays low, so loads stream one per cycle.
//   Test: 24 plane-memory reads through the shared multiplier, issued in turn
//     through the single read port of the plane memory.
//   Derive: 64 multiply-accumulate steps for proj*view, then per plane 4 reads,
//     3 squares, a 32-step square root and four (32+FRAC_BITS)-step divisions;
//     a plane with a zero-length normal skips its divisions. The serial divider
//     dominates.
//   Reset: synchronous, active high. Clears control state only; memories hold
//   whatever they held and must be loaded/derived before use. No clearing pass.
//
`include "sphere_frustum_cull_macros.svh"

module sphere_frustum_cull #(
   parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sfc_pkg::req_type req_payload,
   output logic             busy,
   output logic             rsp_strobe,
   output sfc_pkg::rsp_type rsp_payload
);
   import sfc_pkg::*;

   localparam int NUM_W = 32 + FRAC_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_EXT  = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_TEST = 3'd6;

   localparam logic [4:0] TEST_LAST = 5'(PLANE_DEPTH - 1);

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;        // issue counter of the current phase
   logic       iss_on_ff, iss_on_in;
   logic [2:0] plane_ff, plane_in;
   logic [1:0] j_ff, j_in;            // component under division
   logic       run_ff, run_in;        // root / divider launched
   logic       cull_ff, cull_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   rsp_type    rsp_ff, rsp_in;
   tag_type    p1_ff, p1_in, p2_ff, p2_in;

   // Payload registers
   logic [31:0]        len_ff, len_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff;
   logic [31:0]        raw_ff [4];
   logic [31:0]        p2_dist_ff;

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------
   // Matrix memory: view at bank 0, projection at bank 1, product at bank 2.
   // Two read ports, one write port, registered read data.
   // ---------------------------------------------------------------
   logic [31:0]       mat_mem [MAT_DEPTH];
   logic [MAT_AW-1:0] mat_ra, mat_rb, mat_wa;
   logic              mat_we;
   logic [31:0]       mat_wd, mat_rd_a_ff, mat_rd_b_ff;

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= mat_wd;
      mat_rd_a_ff <= mat_mem[mat_ra];
      mat_rd_b_ff <= mat_mem[mat_rb];
   end

   // Plane memory: plane p at p*4 + {nx, ny, nz, d}.
   logic [31:0]         plane_mem [PLANE_DEPTH];
   logic [PLANE_AW-1:0] plane_ra, plane_wa;
   logic                plane_we;
   logic [31:0]         plane_wd, plane_rd_ff;

   always_ff @(posedge clock) begin
      if (plane_we) plane_mem[plane_wa] <= plane_wd;
      plane_rd_ff <= plane_mem[plane_ra];
   end

   // ---------------------------------------------------------------
   // Issue stage: addresses and tags from the phase counter
   // ---------------------------------------------------------------
   tag_type iss;

   always_comb begin
      iss      = '0;
      iss.vld  = iss_on_ff;
      mat_ra   = '0;
      mat_rb   = '0;
      plane_ra = cnt_ff[4:0];
      unique case (state_ff)
         ST_MUL: begin
            // cnt = {c, r, k}
            mat_ra         = {BANK_PROJ, cnt_ff[1:0], cnt_ff[3:2]};
            mat_rb         = {BANK_VIEW, cnt_ff[5:4], cnt_ff[1:0]};
            iss.first      = (cnt_ff[1:0] == 2'd0);
            iss.last       = (cnt_ff[1:0] == 2'd3);
            iss.final_term = (cnt_ff == 6'd63);
            iss.idx        = {cnt_ff[5:4], cnt_ff[3:2]};
         end
         ST_EXT: begin
            // w = row 4 of column j, e = selected row of column j
            mat_ra         = {BANK_PROD, cnt_ff[1:0], 2'd3};
            mat_rb         = {BANK_PROD, cnt_ff[1:0], plane_ff[2:1]};
            iss.sel        = cnt_ff[1:0];
            iss.final_term = (cnt_ff[1:0] == 2'd3);
         end
         ST_SQ: begin
            iss.sel        = cnt_ff[1:0];
            iss.first      = (cnt_ff[1:0] == 2'd0);
            iss.final_term = (cnt_ff[1:0] == 2'd2);
         end
         ST_TEST: begin
            iss.sel        = cnt_ff[1:0];
            iss.first      = (cnt_ff[1:0] == 2'd0);
            iss.last       = (cnt_ff[1:0] == 2'd3);
            iss.final_term = (cnt_ff[4:0] == TEST_LAST);
         end
         default: iss.vld = 1'b0;
      endcase
   end

   assign p1_in = iss;

   always_comb begin
      p2_in     = p1_ff;
      p2_in.vld = p1_ff.vld && (state_ff != ST_EXT);
   end

   // ---------------------------------------------------------------
   // Operand stage: shared multiplier
   // ---------------------------------------------------------------
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;

   always_comb begin
      mul_a = $signed(mat_rd_a_ff);
      mul_b = $signed(mat_rd_b_ff);
      case (state_ff)
         ST_SQ: begin
            mul_a = $signed(raw_ff[p1_ff.sel]);
            mul_b = $signed(raw_ff[p1_ff.sel]);
         end
         ST_TEST: begin
            mul_a = $signed(plane_rd_ff);
            case (p1_ff.sel)
               2'd0:    mul_b = cx_ff;
               2'd1:    mul_b = cy_ff;
               2'd2:    mul_b = cz_ff;
               default: mul_b = '0;
            endcase
         end
         default: ;
      endcase
   end

   sfc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Plane extraction: row4 -/+ row, saturated
   logic        minus;
   logic [32:0] raw_sum;
   logic        raw_we;

   assign minus   = (plane_ff == 3'd0) || (plane_ff == 3'd3) || (plane_ff == 3'd4);
   assign raw_sum = minus
                  ? ({mat_rd_a_ff[31], mat_rd_a_ff} - {mat_rd_b_ff[31], mat_rd_b_ff})
                  : ({mat_rd_a_ff[31], mat_rd_a_ff} + {mat_rd_b_ff[31], mat_rd_b_ff});
   assign raw_we  = (state_ff == ST_EXT) && p1_ff.vld;

   // ---------------------------------------------------------------
   // Accumulate stage
   // ---------------------------------------------------------------
   logic signed [63:0] prod_sh, term, acc_sum, neg_rad;
   logic               hit;

   assign prod_sh = prod >>> FRAC_BITS;   // floor of the scaled product
   assign neg_rad = -$signed({33'd0, rad_ff});

   always_comb begin
      term = prod_sh;
      if (state_ff == ST_SQ) term = prod;
      else if ((state_ff == ST_TEST) && p2_ff.last)
         term = {{32{p2_dist_ff[31]}}, p2_dist_ff};
   end

   assign acc_sum = (p2_ff.first ? 64'sd0 : $signed(acc_ff)) + term;
   assign acc_in  = p2_ff.vld ? acc_sum : acc_ff;
   assign hit     = (state_ff == ST_TEST) && p2_ff.vld && p2_ff.last && (acc_sum <= neg_rad);

   // Matrix write port: loads while idle, product elements during the multiply phase
   always_comb begin
      mat_we = 1'b0;
      mat_wa = {BANK_PROD, p2_ff.idx};
      mat_wd = sat64(acc_sum);
      if ((state_ff == ST_MUL) && p2_ff.vld && p2_ff.last) begin
         mat_we = 1'b1;
      end else if (accept && ((req_payload.command == CMD_LOAD_VIEW) ||
                              (req_payload.command == CMD_LOAD_PROJ))) begin
         mat_we = 1'b1;
         mat_wa = {(req_payload.command == CMD_LOAD_PROJ) ? BANK_PROJ : BANK_VIEW,
                   req_payload.element_index};
         mat_wd = req_payload.element_value;
      end
   end

   // ---------------------------------------------------------------
   // Square root and normalising divide
   // ---------------------------------------------------------------
   logic          sqrt_start, div_start;
   unit_stat_type sqrt_stat, div_stat;
   logic [31:0]   root;
   logic [31:0]   raw_j, mag;
   logic          neg;
   logic [NUM_W-1:0] numer, quot;
   logic          q_hi;
   logic [31:0]   q_sat;

   sfc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff),
      .stat     (sqrt_stat),
      .root     (root)
   );

   assign raw_j = raw_ff[j_ff];
   assign neg   = raw_j[31];
   assign mag   = neg ? (32'd0 - raw_j) : raw_j;
   assign numer = {mag, {FRAC_BITS{1'b0}}};

   sfc_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (len_ff),
      .stat  (div_stat),
      .quot  (quot)
   );

   assign q_hi = |quot[NUM_W-1:32];

   always_comb begin
      if (!neg) q_sat = (q_hi || quot[31]) ? 32'h7FFF_FFFF : quot[31:0];
      else      q_sat = (q_hi || (quot[31] && |quot[30:0])) ? 32'h8000_0000
                                                           : (32'd0 - quot[31:0]);
   end

   assign plane_wa = {plane_ff, j_ff};

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      iss_on_in     = iss_on_ff;
      plane_in      = plane_ff;
      j_in          = j_ff;
      run_in        = run_ff;
      cull_in       = cull_ff;
      len_in        = len_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      sqrt_start    = 1'b0;
      div_start     = 1'b0;
      plane_we      = 1'b0;
      plane_wd      = '0;

      if (iss_on_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (iss.final_term) iss_on_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.command)
                  CMD_LOAD_VIEW, CMD_LOAD_PROJ: rsp_strobe_in = 1'b1;
                  CMD_DERIVE: begin
                     state_in  = ST_MUL;
                     cnt_in    = '0;
                     iss_on_in = 1'b1;
                     plane_in  = '0;
                  end
                  CMD_TEST: begin
                     state_in  = ST_TEST;
                     cnt_in    = '0;
                     iss_on_in = 1'b1;
                     cull_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            if (p2_ff.vld && p2_ff.final_term) begin
               state_in  = ST_EXT;
               cnt_in    = '0;
               iss_on_in = 1'b1;
            end
         end
         ST_EXT: begin
            if (p1_ff.vld && p1_ff.final_term) begin
               state_in  = ST_SQ;
               cnt_in    = '0;
               iss_on_in = 1'b1;
            end
         end
         ST_SQ: begin
            if (p2_ff.vld && p2_ff.final_term) begin
               state_in = ST_SQRT;
               run_in   = 1'b0;
            end
         end
         ST_SQRT: begin
            if (!run_ff) begin
               sqrt_start = 1'b1;
               run_in     = 1'b1;
            end else if (sqrt_stat.done) begin
               len_in   = root;
               state_in = ST_DIV;
               j_in     = '0;
               run_in   = 1'b0;
            end
         end
         ST_DIV: begin
            // zero-length normal: whole plane stored as zeros
            if ((!run_ff && (len_ff == '0)) || (run_ff && div_stat.done)) begin
               plane_we = 1'b1;
               plane_wd = (len_ff == '0) ? 32'd0 : q_sat;
               run_in   = 1'b0;
               if (j_ff == 2'd3) begin
                  j_in = '0;
                  if (plane_ff == PLANE_LAST) begin
                     state_in      = ST_IDLE;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     plane_in  = plane_ff + 1'b1;
                     state_in  = ST_EXT;
                     cnt_in    = '0;
                     iss_on_in = 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else if (!run_ff) begin
               div_start = 1'b1;
               run_in    = 1'b1;
            end
         end
         ST_TEST: begin
            if (hit) cull_in = 1'b1;
            if (p2_ff.vld && p2_ff.final_term) begin
               state_in              = ST_IDLE;
               rsp_strobe_in         = 1'b1;
               rsp_in.inside_res     = !(cull_ff || hit);
               rsp_in.is_test_result = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         iss_on_ff     <= 1'b0;
         plane_ff      <= '0;
         j_ff          <= '0;
         run_ff        <= 1'b0;
         cull_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
         p1_ff         <= '0;
         p2_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         iss_on_ff     <= iss_on_in;
         plane_ff      <= plane_in;
         j_ff          <= j_in;
         run_ff        <= run_in;
         cull_ff       <= cull_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ff        <= rsp_in;
         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      acc_ff     <= acc_in;
      p2_dist_ff <= plane_rd_ff;
      if (raw_we) raw_ff[p1_ff.sel] <= sat33(raw_sum);
      if (accept) begin
         cx_ff  <= req_payload.centre_x;
         cy_ff  <= req_payload.centre_y;
         cz_ff  <= req_payload.centre_z;
         rad_ff <= req_payload.sphere_radius;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `SFC_ASSERT_NEXT(a_item_answered, start && !busy, rsp_strobe || busy)
   `SFC_ASSERT_SAME(a_inside_only_test, rsp_strobe, !rsp_payload.inside_res || rsp_payload.is_test_result)
   `SFC_ASSERT_SAME(a_div_not_restarted, div_start, !div_stat.busy)
   `SFC_ASSERT_SAME(a_plane_write_in_div, plane_we, state_ff == ST_DIV)
endmodule

/* tb/tb.sv */
// Testbench for sphere_frustum_cull: random and directed matrix loads, derives and sphere tests.
module tb;
   import sfc_pkg::*;

   localparam int FRAC       = 16;
   localparam int CYCLE_CAP  = 3_000_000;   // well above the slowest correct run
   localparam int DRAIN_WAIT = 60;          // loads and tests settle far sooner

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   sphere_frustum_cull #(.FRAC_BITS(FRAC)) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's memories, kept in step with accepted items.
   logic [31:0] view_mem  [16];
   logic [31:0] proj_mem  [16];
   logic [31:0] plane_mem [PLANE_COUNT*4];

   req_type pending_q [$];      // items waiting to be offered
   rsp_type verdict_q [$];      // expected results, oldest first
   int      idle_pct = 0;       // chance per cycle that the sender holds back
   int      fail_count = 0;
   int      cycle_count = 0;

   function automatic longint sat32(input longint x);
      if (x > 64'sd2147483647)  return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // floor(x / 2^FRAC); arithmetic shift rounds towards minus infinity
   function automatic longint fx_mul(input logic [31:0] a, input logic [31:0] b);
      longint p;
      p = longint'($signed(a)) * longint'($signed(b));
      return p >>> FRAC;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic void rebuild_planes();
      longint prod_m [16];
      longint raw [4];
      longint acc, q;
      longint unsigned sumsq, len, mag;
      int row;
      bit subtract;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
               acc += fx_mul(proj_mem[k*4+r], view_mem[c*4+k]);
            prod_m[c*4+r] = sat32(acc);
         end
      for (int p = 0; p < PLANE_COUNT; p++) begin
         row = p >> 1;
         subtract = (p == 0) || (p == 3) || (p == 4);
         for (int j = 0; j < 4; j++)
            raw[j] = sat32(subtract ? prod_m[j*4+3] - prod_m[j*4+row]
                                    : prod_m[j*4+3] + prod_m[j*4+row]);
         sumsq = 0;
         for (int j = 0; j < 3; j++) sumsq += longint'(raw[j] * raw[j]);
         len = int_sqrt(sumsq);
         for (int j = 0; j < 4; j++) begin
            if (len == 0) begin
               plane_mem[p*4+j] = '0;   // degenerate normal: plane cleared
            end else begin
               mag = (raw[j] < 0) ? longint'(-raw[j]) : longint'(raw[j]);
               q = longint'((mag << FRAC) / len);
               plane_mem[p*4+j] = 32'(sat32(raw[j] < 0 ? -q : q));
            end
         end
      end
   endfunction

   function automatic logic sphere_visible(input req_type it);
      longint plane_dist, rad;
      rad = longint'(it.sphere_radius);
      for (int p = 0; p < PLANE_COUNT; p++) begin
         plane_dist = fx_mul(plane_mem[p*4+0], it.centre_x)
                    + fx_mul(plane_mem[p*4+1], it.centre_y)
                    + fx_mul(plane_mem[p*4+2], it.centre_z)
                    + longint'($signed(plane_mem[p*4+3]));
         if (plane_dist <= -rad) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type cull_outcome(input req_type it);
      rsp_type r;
      r = '0;
      case (it.command)
         CMD_LOAD_VIEW: view_mem[it.element_index] = it.element_value;
         CMD_LOAD_PROJ: proj_mem[it.element_index] = it.element_value;
         CMD_DERIVE:    rebuild_planes();
         default: begin
            r.inside_res     = sphere_visible(it);
            r.is_test_result = 1'b1;
         end
      endcase
      return r;
   endfunction

   // Driver: one nonblocking write of start per edge.
   always @(posedge clock) begin
      logic taken;
      taken = start && !busy && !reset;
      if (taken) verdict_q.push_back(cull_outcome(req_payload));
      if (reset) begin
         start <= 1'b0;
      end else if ((taken || !start) && pending_q.size() > 0
                   && $urandom_range(99) >= idle_pct) begin
         start       <= 1'b1;
         req_payload <= pending_q.pop_front();
      end else if (taken) begin
         start <= 1'b0;
      end
   end

   // Monitor: results cannot be held off, so each strobe is checked on the spot.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (verdict_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result %b", rsp_payload);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_payload !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected inside=%b test=%b, got inside=%b test=%b",
                           want.inside_res, want.is_test_result,
                           rsp_payload.inside_res, rsp_payload.is_test_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Fully random fields, so unused bits toggle too.
   function automatic req_type noise_item();
      req_type it;
      logic [223:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(req_type)-1:0];
      return it;
   endfunction

   function automatic logic [31:0] elem_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom;
         default: return 32'(int'($urandom_range(262144)) - 131072);
      endcase
   endfunction

   task automatic put_load(input cmd_type c, input int idx, input logic [31:0] v);
      req_type it;
      it = noise_item();
      it.command = c;
      it.element_index = idx[3:0];
      it.element_value = v;
      pending_q.push_back(it);
   endtask

   task automatic put_derive();
      req_type it;
      it = noise_item();
      it.command = CMD_DERIVE;
      pending_q.push_back(it);
   endtask

   task automatic put_sphere(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] rad);
      req_type it;
      it = noise_item();
      it.command = CMD_TEST;
      it.centre_x = x;
      it.centre_y = y;
      it.centre_z = z;
      it.sphere_radius = rad;
      pending_q.push_back(it);
   endtask

   function automatic logic [31:0] coord_value();
      case ($urandom_range(11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom;
         default: return 32'(int'($urandom_range(2097152)) - 1048576);
      endcase
   endfunction

   function automatic logic [30:0] radius_value();
      case ($urandom_range(7))
         0:       return 31'h7FFF_FFFF;
         1:       return 31'($urandom);
         2:       return '0;
         default: return 31'($urandom_range(1 << 20));
      endcase
   endfunction

   task automatic put_random_test();
      put_sphere(coord_value(), coord_value(), coord_value(), radius_value());
   endtask

   task automatic wait_drained();
      while (pending_q.size() > 0 || start || verdict_q.size() > 0) @(posedge clock);
   endtask

   // One batch: reload all, some or none of the matrix elements, derive, then a run of tests with occasional loads.
   task automatic put_batch();
      int n;
      if ($urandom_range(2) == 0) begin
         for (int i = 0; i < 16; i++) put_load(CMD_LOAD_VIEW, i, elem_value());
         for (int i = 0; i < 16; i++) put_load(CMD_LOAD_PROJ, i, elem_value());
      end else begin
         n = $urandom_range(4);
         repeat (n) put_load(cmd_type'($urandom_range(1)), $urandom_range(15), elem_value());
      end
      put_derive();
      n = $urandom_range(12, 30);
      repeat (n) begin
         if ($urandom_range(9) == 0)
            put_load(cmd_type'($urandom_range(1)), $urandom_range(15), elem_value());
         else
            put_random_test();
      end
   endtask

   initial begin
      int phase_idle [4] = '{0, 84, 0, 34};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: degenerate (all-zero) matrices first, so every normal has zero length.
      for (int i = 0; i < 16; i++) put_load(CMD_LOAD_VIEW, i, 32'h0);
      for (int i = 0; i < 16; i++) put_load(CMD_LOAD_PROJ, i, 32'h0);
      put_derive();
      put_sphere(32'h0, 32'h0, 32'h0, 31'h0);            // distance 0 == -0: culled
      put_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h1);
      // Identity view, simple perspective-like projection.
      for (int i = 0; i < 16; i++)
         put_load(CMD_LOAD_VIEW, i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
      for (int i = 0; i < 16; i++)
         put_load(CMD_LOAD_PROJ, i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
      put_load(CMD_LOAD_PROJ, 14, 32'hFFFE_0000);
      put_load(CMD_LOAD_PROJ, 11, 32'hFFFF_0000);
      put_load(CMD_LOAD_PROJ, 15, 32'h0);
      put_derive();
      put_sphere(32'h0, 32'h0, 32'hFFFB_0000, 31'h0001_0000);
      put_sphere(32'h0, 32'h0, 32'h0, 31'h0);
      put_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      put_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      put_sphere(32'h8000_0000, 32'h0, 32'hFFF6_0000, 31'h0);
      // Saturating matrices: every product overflows.
      for (int i = 0; i < 16; i++) put_load(CMD_LOAD_VIEW, i, 32'h8000_0000);
      for (int i = 0; i < 16; i++) put_load(CMD_LOAD_PROJ, i, 32'h7FFF_FFFF);
      put_derive();
      put_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
      put_sphere(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
      wait_drained();

      // Random phases, each with its own sender idling.
      foreach (phase_idle[ph]) begin
         int queued;
         idle_pct = phase_idle[ph];
         queued = 0;
         while (queued < 95) begin
            put_batch();
            queued = queued + pending_q.size();
            wait_drained();
         end
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_mul.sv
hw/rtl/sfc_sqrt.sv
hw/rtl/sfc_div.sv
hw/rtl/sphere_frustum_cull.sv
tb/tb.sv
